// ----- design/ccs_pkg.sv -----
// Shared types, character codes and the per-item filter step of the comment stripper.
package ccs_pkg;

	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_EOL  = 2'd1;
	localparam logic [1:0] MODE_EOI  = 2'd2;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam logic [1:0] MAX_RES = 2'd3;

	typedef struct packed {
		logic in_block;
		logic in_quote;
		logic held_slash;
		logic star_before;
		logic held_backslash;
		logic dropping_rest;
		logic line_joined;
		logic line_open;
	} ccs_state_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] data;
		logic [2:0]      le;
	} ccs_res_t;

	typedef struct packed {
		ccs_state_t st;
		ccs_res_t   res;
	} ccs_step_t;

	function automatic ccs_step_t put(ccs_step_t s, logic [7:0] c, logic le);
		ccs_step_t o;
		o = s;
		if (s.res.cnt != MAX_RES) begin
			o.res.data[s.res.cnt] = c;
			o.res.le[s.res.cnt]   = le;
			o.res.cnt             = s.res.cnt + 2'd1;
		end
		return o;
	endfunction

	function automatic ccs_step_t plain_char(ccs_step_t s, logic [7:0] c);
		ccs_step_t o;
		o = s;
		if (c == CH_QUOTE) begin
			o.st.in_quote = 1'b1;
			o = put(o, c, 1'b0);
		end else if (c == CH_SLASH) begin
			o.st.held_slash = 1'b1;
		end else begin
			o = put(o, c, 1'b0);
		end
		return o;
	endfunction

	function automatic ccs_step_t logical_char(ccs_step_t s, logic [7:0] c);
		ccs_step_t o;
		o = s;
		if (s.st.dropping_rest) begin
			o = s;
		end else if (s.st.in_block) begin
			if (s.st.star_before && c == CH_SLASH) begin
				o.st.in_block    = 1'b0;
				o.st.star_before = 1'b0;
			end else begin
				o.st.star_before = (c == CH_STAR);
			end
		end else if (s.st.in_quote) begin
			o = put(o, c, 1'b0);
			if (c == CH_QUOTE) begin
				o.st.in_quote = 1'b0;
			end
		end else if (s.st.held_slash) begin
			o.st.held_slash = 1'b0;
			if (c == CH_SLASH) begin
				o.st.dropping_rest = 1'b1;
			end else if (c == CH_STAR) begin
				o.st.in_block    = 1'b1;
				o.st.star_before = 1'b0;
			end else begin
				o = put(o, CH_SLASH, 1'b0);
				o = plain_char(o, c);
			end
		end else begin
			o = plain_char(o, c);
		end
		return o;
	endfunction

	function automatic ccs_step_t close_line(ccs_step_t s);
		ccs_step_t o;
		o = s;
		if (s.st.held_slash && !s.st.dropping_rest) begin
			o = put(o, CH_SLASH, 1'b0);
		end
		o = put(o, 8'h00, 1'b1);
		o.st.in_quote      = 1'b0;
		o.st.held_slash    = 1'b0;
		o.st.star_before   = 1'b0;
		o.st.dropping_rest = 1'b0;
		o.st.line_joined   = 1'b0;
		o.st.line_open     = 1'b0;
		return o;
	endfunction

	function automatic ccs_step_t join_line(ccs_step_t s);
		ccs_step_t o;
		o = s;
		o.st.held_backslash = 1'b0;
		o = logical_char(o, CH_SPACE);
		o.st.line_joined = 1'b1;
		o.st.line_open   = 1'b1;
		return o;
	endfunction

	function automatic ccs_step_t step(ccs_state_t st, logic [1:0] mode, logic [7:0] b);
		ccs_step_t o;
		o     = '0;
		o.st  = st;
		case (mode)
			MODE_BYTE: begin
				o.st.line_open = 1'b1;
				if (o.st.held_backslash) begin
					o.st.held_backslash = 1'b0;
					o = logical_char(o, CH_BACKSLASH);
				end
				if (b == CH_BACKSLASH) begin
					o.st.held_backslash = 1'b1;
				end else begin
					o = logical_char(o, b);
				end
			end
			MODE_EOL: begin
				if (o.st.held_backslash) begin
					o = join_line(o);
				end else begin
					o = close_line(o);
				end
			end
			MODE_EOI: begin
				if (o.st.held_backslash) begin
					o = join_line(o);
				end
				if (o.st.line_open || o.st.line_joined) begin
					o = close_line(o);
				end
			end
			default: begin
				o.st = st;
			end
		endcase
		return o;
	endfunction

endpackage

// ----- design/c_comment_stripper_core.sv -----
// Top level of the streaming C comment stripper.
// Each accepted item waits in the input register; the filter step loads its results
// into the single result register, which emits one result per cycle while ready.
// One item per cycle while each item gives at most one result and the output is
// ready; an item with two or three results holds the input until its last one leaves.
// Reset clears all filter flags and empties the input and result registers.
module c_comment_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic [1:0] s_axis_tuser,  // [1:0] mode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] line_end
	output logic       m_axis_tlast
);

	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [7:0]        byte_s1;
	logic              take;
	ccs_pkg::ccs_res_t res;

	ccs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.valid_s1 (valid_s1),
		.mode_s1  (mode_s1),
		.byte_s1  (byte_s1),
		.take     (take)
	);

	ccs_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.mode_s1 (mode_s1),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	ccs_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.have_item    (valid_s1),
		.take         (take),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.out_line_end (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

endmodule

// ----- design/ccs_in_stage.sv -----
// Input register stage of the comment stripper.
module ccs_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_mode,
	input  logic [7:0] in_byte,
	output logic       valid_s1,
	output logic [1:0] mode_s1,
	output logic [7:0] byte_s1,
	input  logic       take
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= in_mode;
			byte_s1 <= in_byte;
		end
	end

endmodule

// ----- design/ccs_filter.sv -----
// Filter state registers and the single-pass step logic of the comment stripper.
module ccs_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [1:0]        mode_s1,
	input  logic [7:0]        byte_s1,
	output ccs_pkg::ccs_res_t res
);

	ccs_pkg::ccs_state_t st_q;
	ccs_pkg::ccs_step_t  nxt;

	always_comb begin
		nxt = ccs_pkg::step(st_q, mode_s1, byte_s1);
	end

	assign res = nxt.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= nxt.st;
		end
	end

endmodule

// ----- design/ccs_out_buf.sv -----
// Result register that holds up to three results of one item and emits them in order.
module ccs_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  ccs_pkg::ccs_res_t res,
	input  logic              have_item,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_line_end,
	output logic              out_last
);

	logic [2:0][7:0] data_q;
	logic [2:0]      le_q;
	logic [1:0]      cnt_q;
	logic [1:0]      idx_q;
	logic            can_load;
	logic            fire;

	assign out_valid = (idx_q != cnt_q);
	assign fire      = out_valid && out_ready;
	assign can_load  = (idx_q == cnt_q) || (((idx_q + 2'd1) == cnt_q) && out_ready);
	assign take      = have_item && can_load;
	assign out_last  = ((idx_q + 2'd1) == cnt_q);

	always_comb begin
		case (idx_q)
			2'd0: begin
				out_byte     = data_q[0];
				out_line_end = le_q[0];
			end
			2'd1: begin
				out_byte     = data_q[1];
				out_line_end = le_q[1];
			end
			2'd2: begin
				out_byte     = data_q[2];
				out_line_end = le_q[2];
			end
			default: begin
				out_byte     = 8'h00;
				out_line_end = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (take) begin
			cnt_q <= res.cnt;
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= res.data;
			le_q   <= res.le;
		end
	end

endmodule

// ----- tb/c_comment_stripper_core_test.sv -----
// Self-checking testbench of the streaming C comment stripper, checked against a predictor.
`timescale 1ns / 100ps

module c_comment_stripper_core_test;

	localparam logic [1:0] MODE_SKIP = 2'd3;
	localparam int         N_DIR     = 28;
	localparam int         LIMIT     = 200000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       last;
	} strip_out_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       typed;
		logic [1:0] n_res;
		logic [7:0] res_ch;
		logic       res_eol;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{ccs_pkg::MODE_BYTE, 8'hFF,                 1'b1, 2'd1, 8'hFF, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b1, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_BACKSLASH, 1'b1, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, 8'h78,                 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b1, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOL,  8'hFF,                 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_QUOTE,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_BACKSLASH, 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOL,  8'h00,                 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_QUOTE,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_STAR,      1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_STAR,      1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_BACKSLASH, 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOL,  8'hA5,                 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOL,  8'h00,                 1'b1, 2'd1, 8'h00, 1'b1},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_STAR,      1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_SLASH,     1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, ccs_pkg::CH_BACKSLASH, 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOI,  8'hFF,                 1'b0, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOI,  8'h5A,                 1'b1, 2'd0, 8'h00, 1'b0},
		'{MODE_SKIP,          8'hFF,                 1'b1, 2'd0, 8'h00, 1'b0},
		'{ccs_pkg::MODE_BYTE, 8'h00,                 1'b1, 2'd1, 8'h00, 1'b0},
		'{ccs_pkg::MODE_EOI,  8'h00,                 1'b0, 2'd0, 8'h00, 1'b0}
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic [1:0] s_axis_tuser  = ccs_pkg::MODE_BYTE;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	strip_out_t out_q[$];
	strip_out_t step_res[$];

	bit f_block, f_quote, f_slash, f_star, f_bslash, f_drop, f_joined, f_open;

	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int mismatches    = 0;
	int cycle_cnt     = 0;
	int hold_left     = 0;
	bit pressure_on   = 1'b0;
	bit pressure_done = 1'b0;

	c_comment_stripper_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void emit(logic [7:0] c, logic eol);
		strip_out_t e;
		e = '{c, eol, 1'b0};
		if (step_res.size() < 3) begin
			step_res.insert(step_res.size(), e);
		end
	endfunction

	function automatic void take_plain(logic [7:0] c);
		if (c == ccs_pkg::CH_QUOTE) begin
			f_quote = 1'b1;
			emit(c, 1'b0);
		end else if (c == ccs_pkg::CH_SLASH) begin
			f_slash = 1'b1;
		end else begin
			emit(c, 1'b0);
		end
	endfunction

	function automatic void take_logical(logic [7:0] c);
		if (f_drop) begin
			f_drop = 1'b1;
		end else if (f_block) begin
			if (f_star && c == ccs_pkg::CH_SLASH) begin
				f_block = 1'b0;
				f_star  = 1'b0;
			end else begin
				f_star = (c == ccs_pkg::CH_STAR);
			end
		end else if (f_quote) begin
			emit(c, 1'b0);
			if (c == ccs_pkg::CH_QUOTE) begin
				f_quote = 1'b0;
			end
		end else if (f_slash) begin
			f_slash = 1'b0;
			if (c == ccs_pkg::CH_SLASH) begin
				f_drop = 1'b1;
			end else if (c == ccs_pkg::CH_STAR) begin
				f_block = 1'b1;
				f_star  = 1'b0;
			end else begin
				emit(ccs_pkg::CH_SLASH, 1'b0);
				take_plain(c);
			end
		end else begin
			take_plain(c);
		end
	endfunction

	function automatic void end_line();
		if (f_slash && !f_drop) begin
			emit(ccs_pkg::CH_SLASH, 1'b0);
		end
		emit(8'h00, 1'b1);
		f_quote  = 1'b0;
		f_slash  = 1'b0;
		f_star   = 1'b0;
		f_drop   = 1'b0;
		f_joined = 1'b0;
		f_open   = 1'b0;
	endfunction

	function automatic void splice_line();
		f_bslash = 1'b0;
		take_logical(ccs_pkg::CH_SPACE);
		f_joined = 1'b1;
		f_open   = 1'b1;
	endfunction

	function automatic void strip_item(logic [1:0] mode, logic [7:0] data);
		step_res.delete();
		case (mode)
			ccs_pkg::MODE_BYTE: begin
				f_open = 1'b1;
				if (f_bslash) begin
					f_bslash = 1'b0;
					take_logical(ccs_pkg::CH_BACKSLASH);
				end
				if (data == ccs_pkg::CH_BACKSLASH) begin
					f_bslash = 1'b1;
				end else begin
					take_logical(data);
				end
			end
			ccs_pkg::MODE_EOL: begin
				if (f_bslash) begin
					splice_line();
				end else begin
					end_line();
				end
			end
			ccs_pkg::MODE_EOI: begin
				if (f_bslash) begin
					splice_line();
				end
				if (f_open || f_joined) begin
					end_line();
				end
			end
			default: begin
			end
		endcase
		if (step_res.size() > 0) begin
			step_res[step_res.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			return ccs_pkg::CH_SLASH;
		end else if (r < 32) begin
			return ccs_pkg::CH_STAR;
		end else if (r < 40) begin
			return ccs_pkg::CH_QUOTE;
		end else if (r < 52) begin
			return ccs_pkg::CH_BACKSLASH;
		end else if (r < 60) begin
			return ccs_pkg::CH_SPACE;
		end else if (r < 90) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// hold the transfer until accepted, then predict its results
	task automatic offer(input logic [1:0] mode, input logic [7:0] data, input bit predict);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		strip_item(mode, data);
		if (predict) begin
			foreach (step_res[k]) begin
				out_q.insert(out_q.size(), step_res[k]);
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		strip_out_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (out_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer: actual byte=%02h line_end=%0b last=%0b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				exp_res = out_q.pop_front();
				if (exp_res.ch !== m_axis_tdata || exp_res.eol !== m_axis_tuser
						|| exp_res.last !== m_axis_tlast) begin
					mismatches++;
					$display("%0t: expected byte=%02h line_end=%0b last=%0b, actual byte=%02h line_end=%0b last=%0b",
						$time, exp_res.ch, exp_res.eol, exp_res.last,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (pressure_on && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left     = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	initial begin
		int tx_pct [4];
		int rx_pct [4];
		int sent;
		int len;
		int unsigned r;
		strip_out_t row_res;
		tx_pct = '{0, 68, 0, 29};
		rx_pct = '{0, 0, 68, 29};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			offer(DIR_ROWS[i].mode, DIR_ROWS[i].data, !DIR_ROWS[i].typed);
			if (DIR_ROWS[i].typed && DIR_ROWS[i].n_res != 2'd0) begin
				row_res = '{DIR_ROWS[i].res_ch, DIR_ROWS[i].res_eol, 1'b1};
				out_q.insert(out_q.size(), row_res);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			pressure_on  = (ph == 0);
			sent         = 0;
			while (sent < 100) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					offer(MODE_SKIP, 8'($urandom_range(0, 255)), 1'b1);
				end else begin
					len = $urandom_range(0, 10);
					for (int k = 0; k < len; k++) begin
						offer(ccs_pkg::MODE_BYTE, pick_char(), 1'b1);
					end
					sent += len;
					r = $urandom_range(0, 99);
					if (r < 80) begin
						offer(ccs_pkg::MODE_EOL, 8'($urandom_range(0, 255)), 1'b1);
						sent++;
					end else if (r < 92) begin
						offer(ccs_pkg::MODE_EOI, 8'($urandom_range(0, 255)), 1'b1);
						sent++;
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		rx_stall_pct = 0;
		while (out_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
